/* hdl/thr_pkg.sv */
// Types and codes shared by the timestamped history ring.
`default_nettype none

package thr_pkg;

  typedef enum logic [1:0] {
    CMD_LOG   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_STATS = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_QREAD,
    ST_QCHECK,
    ST_QDONE
  } state_t;

  localparam logic [6:0] MAX_RESULTS = 7'd64;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] now_time;
    logic [63:0] record_payload;
    logic [31:0] window_start;
    logic [31:0] window_end;
    logic [6:0]  return_limit;
  } in_word_t;

  typedef struct packed {
    logic        record_valid;
    logic [31:0] record_time;
    logic [63:0] record_data;
    logic [6:0]  returned_so_far;
    logic        last;
    logic [31:0] total_logged;
    logic [31:0] wrap_total;
    logic [7:0]  held_count;
    logic [31:0] oldest_time;
    logic [31:0] newest_time;
  } out_word_t;

endpackage

`default_nettype wire

/* hdl/timestamped_history_ring.sv */
// Timestamped history ring: record memory, command sequencer and query walker.
`default_nettype none

// A ring of DEPTH records (32-bit time plus PAYLOAD_BITS of payload) held in one
// synchronous memory with one write port and one registered read port. Log, stats
// and clear are taken in the accept cycle and then present their result word from
// the emit state. A query runs a setup step, then a memory read and a window test
// for every held record it visits, and a closing step; it stops early once the
// return limit is reached. The walk holds each match back one step so the final
// word can be flagged last. A stalled output register can hold the sequencer in
// the emit, window test or closing step. A new input word is taken whenever the
// sequencer is idle, even while the previous result still waits in the output
// register.
module timestamped_history_ring
  import thr_pkg::*;
#(
  parameter int DEPTH        = 128,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_word_t  in_word,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_word_t out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = 32 + PAYLOAD_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // record memory
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_data_r;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           wp_r, wp_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [31:0]             total_r, total_nxt;
  logic [31:0]             wraps_r, wraps_nxt;
  logic [31:0]             oldest_r, oldest_nxt;
  logic [31:0]             newest_r, newest_nxt;
  logic                    opend_r, opend_nxt;
  logic [AW-1:0]           q_idx_r, q_idx_nxt;
  logic [CW-1:0]           q_left_r, q_left_nxt;
  logic [6:0]              q_n_r, q_n_nxt;
  logic [6:0]              q_lim_r, q_lim_nxt;
  logic [31:0]             ws_r, ws_nxt;
  logic [31:0]             we_r, we_nxt;
  logic                    hold_v_r, hold_v_nxt;
  logic [31:0]             hold_time_r, hold_time_nxt;
  logic [PAYLOAD_BITS-1:0] hold_data_r, hold_data_nxt;
  logic [6:0]              hold_n_r, hold_n_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  logic [AW-1:0]           wp_inc;
  logic [AW-1:0]           q_idx_inc;
  logic                    full;
  logic [CW:0]             oi_sum;
  logic [AW-1:0]           tail_idx;
  logic [6:0]              lim_clamped;
  logic [31:0]             oldest_cur;
  logic [31:0]             rd_time;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    match;
  logic                    out_free;
  logic                    push;
  out_word_t               push_word;
  out_word_t               status_word;
  out_word_t               hold_word;
  logic [CW+7:0]           fill_ext;
  logic [63+PAYLOAD_BITS:0] hold_data_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign wp_inc    = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
  assign q_idx_inc = (q_idx_r == LAST_IDX) ? '0 : q_idx_r + 1'b1;
  assign full      = (fill_r == FULL_CNT);
  assign out_free  = !out_valid_r || !out_stall;

  assign oi_sum   = (CW+1)'(wp_r) + (CW+1)'(DEPTH) - (CW+1)'(fill_r);
  assign tail_idx = (oi_sum >= (CW+1)'(DEPTH)) ? AW'(oi_sum - (CW+1)'(DEPTH))
                                               : AW'(oi_sum);

  assign lim_clamped = (in_word.return_limit > MAX_RESULTS) ? MAX_RESULTS
                                                            : in_word.return_limit;

  assign rd_time = rd_data_r[MW-1:PAYLOAD_BITS];
  assign rd_pay  = rd_data_r[PAYLOAD_BITS-1:0];
  assign match   = ((ws_r == 32'd0) || (rd_time >= ws_r)) && (rd_time <= we_r);

  // an overwrite leaves the new oldest time in the read register
  assign oldest_cur = opend_r ? rd_time : oldest_r;

  assign fill_ext      = {8'd0, fill_r};
  assign hold_data_ext = {64'd0, hold_data_r};

  always_comb begin
    status_word                 = '0;
    status_word.last            = 1'b1;
    status_word.total_logged    = total_r;
    status_word.wrap_total      = wraps_r;
    status_word.held_count      = fill_ext[7:0];
    status_word.oldest_time     = (fill_r != '0) ? oldest_cur : 32'd0;
    status_word.newest_time     = (fill_r != '0) ? newest_r : 32'd0;

    hold_word                   = status_word;
    hold_word.record_valid      = 1'b1;
    hold_word.record_time       = hold_time_r;
    hold_word.record_data       = hold_data_ext[63:0];
    hold_word.returned_so_far   = hold_n_r;
    hold_word.last              = 1'b0;
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    wraps_nxt     = wraps_r;
    oldest_nxt    = oldest_r;
    newest_nxt    = newest_r;
    opend_nxt     = opend_r;
    q_idx_nxt     = q_idx_r;
    q_left_nxt    = q_left_r;
    q_n_nxt       = q_n_r;
    q_lim_nxt     = q_lim_r;
    ws_nxt        = ws_r;
    we_nxt        = we_r;
    hold_v_nxt    = hold_v_r;
    hold_time_nxt = hold_time_r;
    hold_data_nxt = hold_data_r;
    hold_n_nxt    = hold_n_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = q_idx_r;
    push          = 1'b0;
    push_word     = status_word;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_word.cmd)
            CMD_LOG: begin
              mem_we     = 1'b1;
              wp_nxt     = wp_inc;
              total_nxt  = total_r + 32'd1;
              newest_nxt = in_word.now_time;
              if (full) begin
                // fetch the record that is now the oldest
                wraps_nxt = wraps_r + 32'd1;
                mem_re    = 1'b1;
                mem_raddr = wp_inc;
                opend_nxt = 1'b1;
              end else begin
                fill_nxt = fill_r + 1'b1;
                if (fill_r == '0) begin
                  oldest_nxt = in_word.now_time;
                end
              end
              state_nxt = ST_EMIT;
            end
            CMD_CLEAR: begin
              wp_nxt    = '0;
              fill_nxt  = '0;
              state_nxt = ST_EMIT;
            end
            CMD_QUERY: begin
              q_idx_nxt  = tail_idx;
              q_left_nxt = fill_r;
              q_n_nxt    = '0;
              q_lim_nxt  = lim_clamped;
              ws_nxt     = in_word.window_start;
              we_nxt     = (in_word.window_end == 32'd0) ? in_word.now_time
                                                         : in_word.window_end;
              hold_v_nxt = 1'b0;
              if ((fill_r == '0) || (lim_clamped == 7'd0)) begin
                state_nxt = ST_QDONE;
              end else begin
                state_nxt = ST_QREAD;
              end
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          push       = 1'b1;
          oldest_nxt = oldest_cur;
          opend_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      ST_QREAD: begin
        mem_re    = 1'b1;
        mem_raddr = q_idx_r;
        state_nxt = ST_QCHECK;
      end

      ST_QCHECK: begin
        // a new match releases the held one; wait if the output is busy
        if (!(match && hold_v_r && !out_free)) begin
          if (match) begin
            if (hold_v_r) begin
              push      = 1'b1;
              push_word = hold_word;
            end
            hold_v_nxt    = 1'b1;
            hold_time_nxt = rd_time;
            hold_data_nxt = rd_pay;
            hold_n_nxt    = q_n_r + 7'd1;
            q_n_nxt       = q_n_r + 7'd1;
          end
          q_left_nxt = q_left_r - 1'b1;
          q_idx_nxt  = q_idx_inc;
          if ((q_left_r == CW'(1)) || (match && ((q_n_r + 7'd1) == q_lim_r))) begin
            state_nxt = ST_QDONE;
          end else begin
            state_nxt = ST_QREAD;
          end
        end
      end

      ST_QDONE: begin
        if (out_free) begin
          push = 1'b1;
          if (hold_v_r) begin
            push_word      = hold_word;
            push_word.last = 1'b1;
          end
          hold_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= {in_word.now_time, in_word.record_payload[PAYLOAD_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      wraps_r     <= '0;
      opend_r     <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      wraps_r     <= wraps_nxt;
      opend_r     <= opend_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oldest_r    <= oldest_nxt;
    newest_r    <= newest_nxt;
    q_idx_r     <= q_idx_nxt;
    q_left_r    <= q_left_nxt;
    q_n_r       <= q_n_nxt;
    q_lim_r     <= q_lim_nxt;
    ws_r        <= ws_nxt;
    we_r        <= we_nxt;
    hold_time_r <= hold_time_nxt;
    hold_data_r <= hold_data_nxt;
    hold_n_r    <= hold_n_nxt;
    out_word_r  <= out_word_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("held count above depth");

  a_opend_emit: assert property (@(posedge clk) disable iff (!rst_n)
    opend_r |-> (state_r == ST_EMIT))
    else $error("pending oldest fetch outside emit");

  a_hold_query: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> (state_r == ST_QREAD || state_r == ST_QCHECK || state_r == ST_QDONE))
    else $error("held match outside a query");

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QCHECK) |-> (q_n_r < q_lim_r && q_left_r != '0))
    else $error("query walk past its limit");

endmodule

`default_nettype wire
